@@ sv/nfra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the next-fit region allocator.
package nfra_pkg;

  localparam int ROW_BITS = 8;
  localparam int RBW      = 3;
  localparam int LEN_W    = 10;
  localparam int BASE_W   = 9;
  localparam int START_W  = 9;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [LEN_W-1:0]  length;
    logic [BASE_W-1:0] base;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] start_res;
  } rsp_t;

  typedef struct packed {
    logic           hit;
    logic [RBW-1:0] pos;
  } row_hit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

@@ sv/next_fit_region_allocator_unit.sv @@
`timescale 1ns / 1ps
// Next-fit region allocator: map memory, row scanner and request sequencer.
//
// Usage: a request (mode, length, base) enters on req_valid/req_ready and gives
// exactly one response (granted, start_res) on rsp_valid/rsp_ready.
// Allocate scans the used/free map one 8-word row per cycle, first from the
// next-fit pointer to the end, then from word 0. A hit marks the run one row
// per cycle and moves the pointer to the run's end. Free clears base through
// base+length-1, clamped at the end of memory, one row per cycle.
// The map holds R = ceil(MEM_WORDS/8) rows (64 at 512 words). Requests of length
// 0, allocations longer than memory and frees with base past the end go straight
// to the response. The single read port of the map steps one row a cycle.
// One request is in work at a time. A finished response waits in the output
// register while the next request is taken; the block holds in its done step
// until that register is free, so a stalled receiver loses nothing.
// After reset the map is swept clear row by row with req_ready low.
module next_fit_region_allocator_unit #(
  parameter int MEM_WORDS = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  nfra_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output nfra_pkg::rsp_t   rsp
);
  import nfra_pkg::*;

  localparam int ROWS = (MEM_WORDS + ROW_BITS - 1) / ROW_BITS;
  localparam int RW   = $clog2(ROWS);
  localparam int PW   = $clog2(MEM_WORDS + 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  state_t        state, state_next;
  logic [RW-1:0] raddr, raddr_next;
  logic [RW-1:0] prow, prow_next;
  logic          dv, dv_next;
  logic          pass_b, pass_b_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [PW-1:0] need, need_next;
  logic [PW-1:0] from, from_next;
  logic [PW-1:0] ptr, ptr_next;
  logic [PW-1:0] lo, lo_next;
  logic [PW-1:0] hi, hi_next;
  logic [RW-1:0] mrow, mrow_next;
  logic          set_bits, set_bits_next;
  rsp_t          res, res_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;

  logic [ROW_BITS-1:0] ram_rdata;
  logic                ram_we;
  logic [RW-1:0]       ram_waddr;
  logic [ROW_BITS-1:0] ram_wmask;
  logic                ram_wbit;
  logic [ROW_BITS-1:0] mark_mask;
  row_hit_t            row_hit;
  logic [PW-1:0]       row_cnt;
  logic [PW-1:0]       hit_start;
  logic [PW-1:0]       hi_m1;
  logic [LEN_W:0]      free_sum;

  nfra_map_ram #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_ram (
    .clk   (clk),
    .raddr (raddr),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wmask (ram_wmask),
    .wbit  (ram_wbit)
  );

  nfra_row_scan #(
    .MEM_WORDS (MEM_WORDS),
    .PW        (PW),
    .RW        (RW)
  ) u_scan (
    .used       (ram_rdata),
    .row        (prow),
    .floor_addr (from),
    .cnt_in     (cnt),
    .need       (need),
    .hit        (row_hit),
    .cnt_out    (row_cnt)
  );

  assign hit_start = PW'({prow, row_hit.pos}) + PW'(1) - need;
  assign hi_m1     = hi - PW'(1);
  assign free_sum  = {1'b0, req.length} + (LEN_W + 1)'(req.base);
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    logic [PW-1:0] g;
    for (int b = 0; b < ROW_BITS; b++) begin
      g = PW'({mrow, RBW'(b)});
      mark_mask[b] = (g >= lo) && (g < hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      raddr     <= '0;
      dv        <= 1'b0;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      raddr     <= raddr_next;
      dv        <= dv_next;
      ptr       <= ptr_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prow     <= prow_next;
    pass_b   <= pass_b_next;
    cnt      <= cnt_next;
    need     <= need_next;
    from     <= from_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mrow     <= mrow_next;
    set_bits <= set_bits_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    raddr_next     = raddr;
    prow_next      = prow;
    dv_next        = 1'b0;
    pass_b_next    = pass_b;
    cnt_next       = cnt;
    need_next      = need;
    from_next      = from;
    ptr_next       = ptr;
    lo_next        = lo;
    hi_next        = hi;
    mrow_next      = mrow;
    set_bits_next  = set_bits;
    res_next       = res;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = mrow;
    ram_wmask      = mark_mask;
    ram_wbit       = set_bits;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = raddr;
        ram_wmask = '1;
        ram_wbit  = 1'b0;
        if (raddr == LAST_ROW) begin
          raddr_next = '0;
          state_next = ST_IDLE;
        end else begin
          raddr_next = raddr + RW'(1);
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          res_next = '0;
          if (req.mode == MODE_FREE) begin
            res_next.granted = 1'b1;
            if (32'(req.base) >= 32'(MEM_WORDS) || req.length == '0) begin
              state_next = ST_DONE;
            end else begin
              lo_next       = PW'(req.base);
              hi_next       = (32'(free_sum) > 32'(MEM_WORDS)) ? PW'(MEM_WORDS)
                                                                : PW'(free_sum);
              mrow_next     = RW'(req.base >> RBW);
              set_bits_next = 1'b0;
              state_next    = ST_MARK;
            end
          end else if (req.length == '0 || 32'(req.length) > 32'(MEM_WORDS)) begin
            state_next = ST_DONE;
          end else begin
            need_next = PW'(req.length);
            cnt_next  = '0;
            if (ptr >= PW'(MEM_WORDS)) begin
              pass_b_next = 1'b1;
              from_next   = '0;
              raddr_next  = '0;
            end else begin
              pass_b_next = 1'b0;
              from_next   = ptr;
              raddr_next  = RW'(ptr >> RBW);
            end
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        prow_next  = raddr;
        dv_next    = 1'b1;
        raddr_next = (raddr == LAST_ROW) ? raddr : raddr + RW'(1);
        if (dv) begin
          cnt_next = row_cnt;
          if (row_hit.hit) begin
            lo_next       = hit_start;
            hi_next       = hit_start + need;
            mrow_next     = RW'(hit_start >> RBW);
            set_bits_next = 1'b1;
            ptr_next      = hit_start + need;
            res_next      = '{granted: 1'b1, start_res: START_W'(hit_start)};
            dv_next       = 1'b0;
            state_next    = ST_MARK;
          end else if (prow == LAST_ROW) begin
            dv_next = 1'b0;
            if (!pass_b) begin
              pass_b_next = 1'b1;
              from_next   = '0;
              raddr_next  = '0;
              cnt_next    = '0;
            end else begin
              res_next   = '0;
              state_next = ST_DONE;
            end
          end
        end
      end

      ST_MARK: begin
        ram_we = 1'b1;
        if (mrow == RW'(hi_m1 >> RBW)) begin
          state_next = ST_DONE;
        end else begin
          mrow_next = mrow + RW'(1);
        end
      end

      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != ST_IDLE)
    else $error("accepted request did not start work");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("response raised outside the done step");

  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> lo < hi && hi <= PW'(MEM_WORDS))
    else $error("mark range empty or past end of memory");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && dv |-> cnt <= PW'(MEM_WORDS) && ptr <= PW'(MEM_WORDS))
    else $error("run count or pointer out of range");

endmodule

@@ sv/nfra_map_ram.sv @@
`timescale 1ns / 1ps
// Used/free map memory: one row of bits per address, bit-masked write, registered read.
module nfra_map_ram #(
  parameter int ROWS = 64,
  parameter int RW   = 6
) (
  input  logic                          clk,
  input  logic [RW-1:0]                 raddr,
  output logic [nfra_pkg::ROW_BITS-1:0] rdata,
  input  logic                          we,
  input  logic [RW-1:0]                 waddr,
  input  logic [nfra_pkg::ROW_BITS-1:0] wmask,
  input  logic                          wbit
);
  import nfra_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < ROW_BITS; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wbit;
        end
      end
    end
  end

endmodule

@@ sv/nfra_row_scan.sv @@
`timescale 1ns / 1ps
// Free-run counter for one map row: extends the running count and finds the first fit.
module nfra_row_scan #(
  parameter int MEM_WORDS = 512,
  parameter int PW        = 10,
  parameter int RW        = 6
) (
  input  logic [nfra_pkg::ROW_BITS-1:0] used,
  input  logic [RW-1:0]                 row,
  input  logic [PW-1:0]                 floor_addr,
  input  logic [PW-1:0]                 cnt_in,
  input  logic [PW-1:0]                 need,
  output nfra_pkg::row_hit_t            hit,
  output logic [PW-1:0]                 cnt_out
);
  import nfra_pkg::*;

  logic [ROW_BITS-1:0] used_eff;
  logic [PW-1:0]       run_cnt [ROW_BITS];

  always_comb begin
    logic [PW-1:0] g;
    for (int b = 0; b < ROW_BITS; b++) begin
      g = PW'({row, RBW'(b)});
      used_eff[b] = used[b] || (g < floor_addr) || (g >= PW'(MEM_WORDS));
    end
  end

  always_comb begin
    logic           any_used;
    logic [RBW-1:0] last_pos;
    for (int i = 0; i < ROW_BITS; i++) begin
      any_used = 1'b0;
      last_pos = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
        if (j <= i && used_eff[j]) begin
          any_used = 1'b1;
          last_pos = RBW'(j);
        end
      end
      run_cnt[i] = any_used ? PW'(RBW'(i) - last_pos) : cnt_in + PW'(i + 1);
    end
  end

  always_comb begin
    hit = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (run_cnt[i] >= need) begin
        hit.hit = 1'b1;
        hit.pos = RBW'(i);
      end
    end
    cnt_out = run_cnt[ROW_BITS-1];
  end

endmodule

@@ dv/nfra_allocation_checker.sv @@
`timescale 1ns / 1ps
// Checker for the next-fit region allocator: predicts every request's response and compares.
module nfra_allocation_checker #(
  parameter int MEM_WORDS = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  nfra_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  nfra_pkg::rsp_t rsp,
  output int             fail_count,
  output int             outstanding,
  output int             alloc_grants,
  output int             alloc_denials
);
  import nfra_pkg::*;

  logic [MEM_WORDS-1:0] used_words;
  int unsigned          fit_ptr;
  rsp_t                 pending_grants[$];
  int                   errs;
  int                   grants;
  int                   denials;

  function automatic bit seek_hole(input int unsigned from, input int unsigned need,
                                   output int unsigned at);
    int unsigned x;
    int unsigned s;
    x  = from;
    at = 0;
    while (x < MEM_WORDS) begin
      if (used_words[x]) begin
        x++;
      end else begin
        s = x;
        while (x < MEM_WORDS && !used_words[x]) x++;
        if (x - s >= need) begin
          at = s;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t allocate_or_free(input req_t r);
    rsp_t        o;
    int unsigned stop;
    int unsigned at;
    int unsigned from;
    bit          hit;
    o = '0;
    if (r.mode == MODE_FREE) begin
      stop = r.base + r.length;
      if (stop > MEM_WORDS) stop = MEM_WORDS;
      for (int unsigned x = r.base; x < stop; x++) used_words[x] = 1'b0;
      o.granted = 1'b1;
      return o;
    end
    if (r.length == 0 || r.length > MEM_WORDS) begin
      denials++;
      return o;
    end
    from = (fit_ptr > MEM_WORDS) ? MEM_WORDS : fit_ptr;
    hit  = seek_hole(from, r.length, at);
    if (!hit) hit = seek_hole(0, r.length, at);
    if (!hit) begin
      denials++;
      return o;
    end
    for (int unsigned x = at; x < at + r.length; x++) used_words[x] = 1'b1;
    fit_ptr     = at + r.length;
    o.granted   = 1'b1;
    o.start_res = START_W'(at);
    grants++;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      used_words = '0;
      fit_ptr    = 0;
      pending_grants.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_grants.size() == 0) begin
          errs++;
          $error("response with no request outstanding: granted %0d start_res %0d",
                 rsp.granted, rsp.start_res);
        end else begin
          want = pending_grants.pop_front();
          if (rsp.granted !== want.granted) begin
            errs++;
            $error("granted: expected %0d, actual %0d", want.granted, rsp.granted);
          end
          if (rsp.start_res !== want.start_res) begin
            errs++;
            $error("start_res: expected %0d, actual %0d", want.start_res, rsp.start_res);
          end
        end
      end
      if (req_valid && req_ready) pending_grants.push_back(allocate_or_free(req));
    end
    fail_count    <= errs;
    outstanding   <= pending_grants.size();
    alloc_grants  <= grants;
    alloc_denials <= denials;
  end

endmodule

@@ dv/tb_next_fit_region_allocator_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the next-fit region allocator: stimulus, flow control and verdict.
module tb_next_fit_region_allocator_unit;
  import nfra_pkg::*;

  localparam int MEM_WORDS    = 512;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RX_HOLD      = 400;
  localparam int SETTLE       = 250;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  req_t req       = '0;
  rsp_t rsp;

  logic steady    = 1'b0;
  logic rx_hold   = 1'b0;
  int   quiet     = 0;
  int   n_alloc   = 0;
  int   n_free    = 0;

  int   fail_count;
  int   outstanding;
  int   alloc_grants;
  int   alloc_denials;

  next_fit_region_allocator_unit #(.MEM_WORDS(MEM_WORDS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  nfra_allocation_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .alloc_grants  (alloc_grants),
    .alloc_denials (alloc_denials)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic req_t make_req(input logic m, input int unsigned len,
                                    input int unsigned b);
    req_t r;
    r.mode   = m;
    r.length = LEN_W'(len);
    r.base   = BASE_W'(b);
    return r;
  endfunction

  task automatic push_request(input req_t r);
    while (!steady && $urandom_range(99) < 37) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    if (r.mode == MODE_FREE) n_free++;
    else n_alloc++;
  endtask

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      rsp_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", quiet);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    req_t        r;
    int unsigned pick;
    int unsigned len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_request(make_req(MODE_ALLOC, 0, 0));
    push_request(make_req(MODE_ALLOC, 1023, 511));
    push_request(make_req(MODE_ALLOC, 513, 0));
    push_request(make_req(MODE_ALLOC, 512, 0));
    push_request(make_req(MODE_ALLOC, 1, 0));
    push_request(make_req(MODE_FREE, 1023, 511));
    push_request(make_req(MODE_ALLOC, 1, 0));
    push_request(make_req(MODE_FREE, 0, 0));
    push_request(make_req(MODE_FREE, 512, 0));
    push_request(make_req(MODE_ALLOC, 512, 0));
    push_request(make_req(MODE_FREE, 3, 10));
    push_request(make_req(MODE_FREE, 8, 20));
    push_request(make_req(MODE_ALLOC, 5, 0));
    push_request(make_req(MODE_FREE, 512, 0));
    push_request(make_req(MODE_ALLOC, 10, 0));
    push_request(make_req(MODE_ALLOC, 20, 0));
    push_request(make_req(MODE_FREE, 5, 40));
    push_request(make_req(MODE_FREE, 5, 40));
    push_request(make_req(MODE_ALLOC, 7, 0));
    push_request(make_req(MODE_FREE, 1023, 300));
    push_request(make_req(MODE_ALLOC, 300, 0));
    push_request(make_req(MODE_FREE, 512, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 600 && n < 900);
      if (n == 300) rx_hold <= 1'b1;
      if (n == 1000) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      pick = $urandom_range(99);
      if ($urandom_range(99) < 55) begin
        if (pick < 80) len = $urandom_range(32, 1);
        else if (pick < 95) len = $urandom_range(200, 33);
        else len = $urandom_range(1023, 0);
        r = make_req(MODE_ALLOC, len, $urandom_range(511));
      end else if (pick < 3) begin
        r = make_req(MODE_FREE, 512, 0);
      end else begin
        if (pick < 85) len = $urandom_range(48, 1);
        else len = $urandom_range(1023, 0);
        r = make_req(MODE_FREE, len, $urandom_range(511));
      end
      push_request(r);
    end
    req_valid <= 1'b0;
    steady    <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Run sent %0d requests: %0d allocate, %0d free.", n_alloc + n_free, n_alloc,
             n_free);
    $display("Allocations granted %0d, denied %0d; mismatches %0d.", alloc_grants,
             alloc_denials, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/nfra_pkg.sv
sv/nfra_map_ram.sv
sv/nfra_row_scan.sv
sv/next_fit_region_allocator_unit.sv
dv/nfra_allocation_checker.sv
dv/tb_next_fit_region_allocator_unit.sv
